### rtl/core/ahpl_pkg.sv
`timescale 1ns / 1ps

package ahpl_pkg;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_I,
    ST_DIV_I,
    ST_MUL_K,
    ST_MUL_PITCH,
    ST_MUL_RATE,
    ST_OUT_PREP,
    ST_DIV_OUT,
    ST_DONE
  } ahpl_state_t;

  // item fields
  localparam int ERR_W      = 24;
  localparam int PITCH_W    = 16;
  localparam int RATE_W     = 20;
  localparam int OUT_W      = 15;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 16;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 22;
  localparam int OFF_W      = 22;
  localparam int GAIN_W     = 18;
  localparam int LIMIT_W    = 14;
  localparam int INTEG_W    = 24;

  localparam logic [CFG_IDX_W-1:0] REG_ALT_OFFSET    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ATTITUDE_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING_GAIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT   = 3'd5;

  localparam logic [OFF_W-1:0]   RST_ALT_OFFSET    = 22'd0;
  localparam logic [GAIN_W-1:0]  RST_ERROR_GAIN    = 18'd60490;
  localparam logic [GAIN_W-1:0]  RST_INTEGRAL_GAIN = 18'd1842;
  localparam logic [GAIN_W-1:0]  RST_ATTITUDE_GAIN = 18'd37880;
  localparam logic [GAIN_W-1:0]  RST_DAMPING_GAIN  = 18'd2092;
  localparam logic [LIMIT_W-1:0] RST_INTEG_LIMIT   = 14'd5120;

  // serial unit and datapath widths
  localparam int ACC_W   = 37;
  localparam int MPL_W   = 22;
  localparam int CNT_W   = 5;
  localparam int REM_W   = 6;
  localparam int E_MAG_W = 13;
  localparam int COEF_W  = 10;
  localparam int P_W     = 15;
  localparam int K_W     = 19;
  localparam int T_W     = 39;
  localparam int X_W     = 28;

  // arithmetic constants
  localparam logic [ERR_W:0]      E_MAX        = 25'd5120;
  localparam logic [15:0]         P_MAG_MAX    = 16'd11520;
  localparam logic [P_W-1:0]      P_MAX        = 15'd11520;
  localparam logic [31:0]         P_ROUND      = 32'd32768;
  localparam logic [31:0]         I_ROUND      = 32'd6400;
  localparam logic [COEF_W-1:0]   SCHED_COEF   = 10'd983;
  localparam logic [PITCH_W-1:0]  SCHED_THRESH = 16'd2560;
  localparam logic [24:0]         K_ROUND      = 25'd128;
  localparam logic [REM_W:0]      INT_DIV_K    = 7'd25;
  localparam logic [REM_W:0]      OUT_DIV_K    = 7'd45;
  localparam logic [24:0]         S_MAX        = 25'd2949120;
  localparam logic [T_W-1:0]      OUT_ROUND    = 39'd23040;
  localparam logic [X_W-1:0]      OUT_BIG      = 28'd663615;
  localparam logic [OUT_W-1:0]    OUT_MAX      = 15'd14746;

endpackage

### rtl/core/altitude_hold_pitch_loop.sv
// channel   dir   handshake                 payload
// in_       in    in_tvalid / in_tready     in_tdata: altitude_error, pitch_angle, pitch_rate
// out_      out   out_tvalid / out_tready   out_tdata: elevator_command
// cfg_      in    cfg_valid / cfg_ready     cfg_index, cfg_data (register write)
//
// a new item is accepted only in idle, after the last result has gone to the
// output register. the work is done by one shared shift-add multiplier
// and restoring divider that retire one bit per cycle over seven operations
// reset clears the sequencer, the integrator and the output valid, and loads
// the register defaults; the output register lets the next item start while
// a result still waits, and the sequencer only holds at the end for that slot
`timescale 1ns / 1ps

module altitude_hold_pitch_loop
  import ahpl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // item in
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // altitude_error[23:0], pitch_angle[39:24],
                                            // pitch_rate[59:40], zeros above
  // item out
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // elevator_command[14:0], zero above
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [OFF_W-1:0]   off_r;
  logic [GAIN_W-1:0]  kp_r;
  logic [GAIN_W-1:0]  ki_r;
  logic [GAIN_W-1:0]  ka_r;
  logic [GAIN_W-1:0]  kd_r;
  logic [LIMIT_W-1:0] lim_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r <= RST_ALT_OFFSET;
      kp_r  <= RST_ERROR_GAIN;
      ki_r  <= RST_INTEGRAL_GAIN;
      ka_r  <= RST_ATTITUDE_GAIN;
      kd_r  <= RST_DAMPING_GAIN;
      lim_r <= RST_INTEG_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ALT_OFFSET:    off_r <= cfg_data[OFF_W-1:0];
        REG_ERROR_GAIN:    kp_r  <= cfg_data[GAIN_W-1:0];
        REG_INTEGRAL_GAIN: ki_r  <= cfg_data[GAIN_W-1:0];
        REG_ATTITUDE_GAIN: ka_r  <= cfg_data[GAIN_W-1:0];
        REG_DAMPING_GAIN:  kd_r  <= cfg_data[GAIN_W-1:0];
        REG_INTEG_LIMIT:   lim_r <= cfg_data[LIMIT_W-1:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // input front end: offset, clamp to +-20 m, split into sign and magnitude
  // --------------------------------------------------------------------------
  logic [ERR_W-1:0]   in_err;
  logic [PITCH_W-1:0] in_pitch;
  logic [RATE_W-1:0]  in_rate;

  assign in_err   = in_tdata[ERR_W-1:0];
  assign in_pitch = in_tdata[ERR_W+PITCH_W-1:ERR_W];
  assign in_rate  = in_tdata[ERR_W+PITCH_W+RATE_W-1:ERR_W+PITCH_W];

  logic [ERR_W:0]     e_sum;
  logic               fe_e_neg;
  logic [E_MAG_W-1:0] fe_e_mag;
  logic [PITCH_W-1:0] fe_pitch_mag;
  logic [RATE_W-1:0]  fe_rate_mag;

  // full-width sum so an out-of-range offset still clamps cleanly
  assign e_sum = {in_err[ERR_W-1], in_err} + {{(ERR_W+1-OFF_W){off_r[OFF_W-1]}}, off_r};

  always_comb begin
    if ($signed(e_sum) > $signed(E_MAX)) begin
      fe_e_neg = 1'b0;
      fe_e_mag = E_MAX[E_MAG_W-1:0];
    end else if ($signed(e_sum) < -$signed(E_MAX)) begin
      fe_e_neg = 1'b1;
      fe_e_mag = E_MAX[E_MAG_W-1:0];
    end else begin
      fe_e_neg = e_sum[ERR_W];
      fe_e_mag = e_sum[ERR_W] ? (E_MAG_W'(0) - e_sum[E_MAG_W-1:0]) : e_sum[E_MAG_W-1:0];
    end
  end

  assign fe_pitch_mag = in_pitch[PITCH_W-1] ? (PITCH_W'(0) - in_pitch) : in_pitch;
  assign fe_rate_mag  = in_rate[RATE_W-1]   ? (RATE_W'(0) - in_rate)   : in_rate;

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  ahpl_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [ACC_W-1:0]   mcand_r, mcand_nxt;
  logic [MPL_W-1:0]   mpl_r, mpl_nxt;     // multiplier bits out / dividend in, quotient
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic               e_neg_r, e_neg_nxt;
  logic [E_MAG_W-1:0] e_mag_r, e_mag_nxt;
  logic               pitch_neg_r, pitch_neg_nxt;
  logic [PITCH_W-1:0] pitch_mag_r, pitch_mag_nxt;
  logic               rate_neg_r, rate_neg_nxt;
  logic [RATE_W-1:0]  rate_mag_r, rate_mag_nxt;
  logic [P_W-1:0]     p_r, p_nxt;         // proportional term, Q.8 signed
  logic [INTEG_W-1:0] integ_r, integ_nxt; // integrator, Q.16 signed
  logic [T_W-1:0]     t_r, t_nxt;         // Q.24 signed command before scaling
  logic               big_r, big_nxt;     // scaled value past the output clamp
  logic [OUT_W-1:0]   y_r, y_nxt;
  logic               out_tvalid_r;
  logic [OUT_W-1:0]   out_data_r;

  // --------------------------------------------------------------------------
  // sequencer control
  // --------------------------------------------------------------------------
  logic           cnt_zero;
  logic           step_mul;
  logic           step_div;
  logic [REM_W:0] div_k;
  logic           out_load;

  assign cnt_zero = (cnt_r == '0);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:      if (in_tvalid) state_nxt = ST_MUL_P;
      ST_MUL_P:     if (cnt_zero)  state_nxt = ST_MUL_I;
      ST_MUL_I:     if (cnt_zero)  state_nxt = ST_DIV_I;
      ST_DIV_I:     if (cnt_zero)  state_nxt = ST_MUL_K;
      ST_MUL_K:     if (cnt_zero)  state_nxt = ST_MUL_PITCH;
      ST_MUL_PITCH: if (cnt_zero)  state_nxt = ST_MUL_RATE;
      ST_MUL_RATE:  if (cnt_zero)  state_nxt = ST_OUT_PREP;
      ST_OUT_PREP:                 state_nxt = ST_DIV_OUT;
      ST_DIV_OUT:   if (cnt_zero)  state_nxt = ST_DONE;
      ST_DONE:      if (out_load)  state_nxt = ST_IDLE;
      default:                     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (state_r == ST_IDLE);
    step_mul  = (state_r inside {ST_MUL_P, ST_MUL_I, ST_MUL_K, ST_MUL_PITCH, ST_MUL_RATE})
                && !cnt_zero;
    step_div  = (state_r inside {ST_DIV_I, ST_DIV_OUT}) && !cnt_zero;
    div_k     = (state_r == ST_DIV_I) ? INT_DIV_K : OUT_DIV_K;
    // result slot is free when empty or being drained this cycle
    out_load  = (state_r == ST_DONE) && (!out_tvalid_r || out_tready);
  end

  // --------------------------------------------------------------------------
  // datapath
  // --------------------------------------------------------------------------
  logic [REM_W:0]     div_r2;
  logic               div_ge;
  logic [31:0]        p_round;
  logic [15:0]        p_mag;
  logic [P_W-1:0]     p_sat;
  logic [31:0]        i_round;
  logic [K_W-2:0]     i_q;
  logic [K_W-1:0]     i_inc;
  logic [ERR_W:0]     i_sum;
  logic [ERR_W:0]     lim_ext;
  logic [24:0]        s_sum;
  logic [24:0]        s_sat;
  logic [24:0]        k_round;
  logic [K_W-1:0]     k_val;
  logic [T_W-1:0]     acc_ext;
  logic [T_W-1:0]     o_sum;
  logic [X_W-1:0]     o_x;
  logic [OUT_W-1:0]   y_mag;

  // one restoring-division bit
  assign div_r2 = {rem_r, mpl_r[MPL_W-1]};
  assign div_ge = (div_r2 >= div_k);

  // round half away from zero on magnitudes, then clamp
  assign p_round = acc_r[31:0] + P_ROUND;
  assign p_mag   = p_round[31:16];
  assign p_sat   = (p_mag > P_MAG_MAX) ? P_MAX : p_mag[P_W-1:0];

  // integrator increment: /12800 as >>9 then serial /25
  assign i_round = acc_r[31:0] + I_ROUND;
  assign i_q     = mpl_r[K_W-2:0];
  assign i_inc   = e_neg_r ? (K_W'(0) - {1'b0, i_q}) : {1'b0, i_q};
  assign i_sum   = {integ_r[INTEG_W-1], integ_r} + {{(ERR_W+1-K_W){i_inc[K_W-1]}}, i_inc};
  assign lim_ext = {3'b000, lim_r, 8'h00};

  // p + i in Q.16, clamped to +-45
  assign s_sum = {{2{p_r[P_W-1]}}, p_r, 8'h00} + {integ_r[INTEG_W-1], integ_r};
  always_comb begin
    if ($signed(s_sum) > $signed(S_MAX)) begin
      s_sat = S_MAX;
    end else if ($signed(s_sum) < -$signed(S_MAX)) begin
      s_sat = 25'd0 - S_MAX;
    end else begin
      s_sat = s_sum;
    end
  end

  // scheduled pitch gain, grows with |pitch| at or past 10 degrees
  assign k_round = acc_r[24:0] + K_ROUND;
  assign k_val   = {1'b0, ka_r}
                 + ((pitch_mag_r >= SCHED_THRESH) ? {2'b00, k_round[24:8]} : K_W'(0));

  assign acc_ext = {{(T_W-ACC_W){1'b0}}, acc_r};

  // |t| + 23040 in one add, then >>10 ahead of the /45
  assign o_sum = t_r[T_W-1] ? (OUT_ROUND - t_r) : (t_r + OUT_ROUND);
  assign o_x   = o_sum[X_W+9:10];

  assign y_mag = big_r ? OUT_MAX : mpl_r[OUT_W-1:0];

  always_comb begin
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    mpl_nxt       = mpl_r;
    rem_nxt       = rem_r;
    e_neg_nxt     = e_neg_r;
    e_mag_nxt     = e_mag_r;
    pitch_neg_nxt = pitch_neg_r;
    pitch_mag_nxt = pitch_mag_r;
    rate_neg_nxt  = rate_neg_r;
    rate_mag_nxt  = rate_mag_r;
    p_nxt         = p_r;
    integ_nxt     = integ_r;
    t_nxt         = t_r;
    big_nxt       = big_r;
    y_nxt         = y_r;

    // shift-add multiply, one multiplier bit per cycle
    if (step_mul) begin
      if (mpl_r[0]) begin
        acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt = {mcand_r[ACC_W-2:0], 1'b0};
      mpl_nxt   = {1'b0, mpl_r[MPL_W-1:1]};
      cnt_nxt   = cnt_r - 1'b1;
    end

    // restoring divide by a small constant, one quotient bit per cycle
    if (step_div) begin
      rem_nxt = div_ge ? REM_W'(div_r2 - div_k) : div_r2[REM_W-1:0];
      mpl_nxt = {mpl_r[MPL_W-2:0], div_ge};
      cnt_nxt = cnt_r - 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          e_neg_nxt     = fe_e_neg;
          e_mag_nxt     = fe_e_mag;
          pitch_neg_nxt = in_pitch[PITCH_W-1];
          pitch_mag_nxt = fe_pitch_mag;
          rate_neg_nxt  = in_rate[RATE_W-1];
          rate_mag_nxt  = fe_rate_mag;
          acc_nxt       = '0;
          mcand_nxt     = ACC_W'(kp_r);
          mpl_nxt       = MPL_W'(fe_e_mag);
          cnt_nxt       = CNT_W'(E_MAG_W);
        end
      end
      ST_MUL_P: begin
        if (cnt_zero) begin
          p_nxt     = e_neg_r ? (P_W'(0) - p_sat) : p_sat;
          acc_nxt   = '0;
          mcand_nxt = ACC_W'(ki_r);
          mpl_nxt   = MPL_W'(e_mag_r);
          cnt_nxt   = CNT_W'(E_MAG_W);
        end
      end
      ST_MUL_I: begin
        if (cnt_zero) begin
          mpl_nxt = i_round[MPL_W+8:9];
          rem_nxt = '0;
          cnt_nxt = CNT_W'(MPL_W);
        end
      end
      ST_DIV_I: begin
        if (cnt_zero) begin
          if ($signed(i_sum) > $signed(lim_ext)) begin
            integ_nxt = lim_ext[INTEG_W-1:0];
          end else if ($signed(i_sum) < -$signed(lim_ext)) begin
            integ_nxt = INTEG_W'(0) - lim_ext[INTEG_W-1:0];
          end else begin
            integ_nxt = i_sum[INTEG_W-1:0];
          end
          acc_nxt   = '0;
          mcand_nxt = ACC_W'(pitch_mag_r);
          mpl_nxt   = MPL_W'(SCHED_COEF);
          cnt_nxt   = CNT_W'(COEF_W);
        end
      end
      ST_MUL_K: begin
        // p and the integrator are settled here, so s*256 seeds t
        t_nxt = {{(T_W-33){s_sat[24]}}, s_sat, 8'h00};
        if (cnt_zero) begin
          acc_nxt   = '0;
          mcand_nxt = ACC_W'(k_val);
          mpl_nxt   = MPL_W'(pitch_mag_r);
          cnt_nxt   = CNT_W'(PITCH_W);
        end
      end
      ST_MUL_PITCH: begin
        if (cnt_zero) begin
          t_nxt     = pitch_neg_r ? (t_r + acc_ext) : (t_r - acc_ext);
          acc_nxt   = '0;
          mcand_nxt = ACC_W'(rate_mag_r);
          mpl_nxt   = MPL_W'(kd_r);
          cnt_nxt   = CNT_W'(GAIN_W);
        end
      end
      ST_MUL_RATE: begin
        if (cnt_zero) begin
          t_nxt = rate_neg_r ? (t_r + acc_ext) : (t_r - acc_ext);
        end
      end
      ST_OUT_PREP: begin
        // anything at or past 14747*45 clamps, so 20 dividend bits suffice
        big_nxt = (o_x >= OUT_BIG);
        mpl_nxt = {2'b00, o_x[19:0]};
        rem_nxt = '0;
        cnt_nxt = CNT_W'(MPL_W);
      end
      ST_DIV_OUT: begin
        if (cnt_zero) begin
          y_nxt = t_r[T_W-1] ? (OUT_W'(0) - y_mag) : y_mag;
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      integ_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      integ_r <= integ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r       <= acc_nxt;
    mcand_r     <= mcand_nxt;
    mpl_r       <= mpl_nxt;
    rem_r       <= rem_nxt;
    e_neg_r     <= e_neg_nxt;
    e_mag_r     <= e_mag_nxt;
    pitch_neg_r <= pitch_neg_nxt;
    pitch_mag_r <= pitch_mag_nxt;
    rate_neg_r  <= rate_neg_nxt;
    rate_mag_r  <= rate_mag_nxt;
    p_r         <= p_nxt;
    t_r         <= t_nxt;
    big_r       <= big_nxt;
    y_r         <= y_nxt;
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= y_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_DATA_W-OUT_W){1'b0}}, out_data_r};

`ifndef NO_ASSERTIONS
  // integrator sits inside the current limit once updated
  a_integ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL_K) |->
      ($signed({integ_r[INTEG_W-1], integ_r}) <= $signed(lim_ext) &&
       $signed({integ_r[INTEG_W-1], integ_r}) >= -$signed(lim_ext)))
    else $error("integrator outside its limit");

  // proportional term clamped to +-45 degrees
  a_p_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL_K) |->
      ($signed(p_r) <= $signed(P_MAX) && $signed(p_r) >= -$signed(P_MAX)))
    else $error("proportional term out of range");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_tready) |-> !out_load)
    else $error("result register overwritten");

  // a loaded result is presented next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_tvalid_r)
    else $error("loaded result not presented");

  // presented command within +-0.45
  a_out_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |->
      ($signed(out_data_r) <= $signed(OUT_MAX) && $signed(out_data_r) >= -$signed(OUT_MAX)))
    else $error("elevator command out of range");
`endif

endmodule

### dv/pitch_loop_checker.sv
`timescale 1ns / 1ps

module pitch_loop_checker
  import ahpl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatch_count,
  output int                    awaiting_count
);

  localparam longint E_LIMIT     = 5120;
  localparam longint P_LIMIT     = 11520;
  localparam longint INTEG_SCALE = 12800;
  localparam longint SUM_LIMIT   = 45 * 65536;
  localparam longint GAIN_KNEE   = 2560;
  localparam longint GAIN_SLOPE  = 983;
  localparam longint OUT_SCALE   = 46080;
  localparam longint OUT_LIMIT   = 14746;

  logic signed [OFF_W-1:0] alt_offset;
  logic [GAIN_W-1:0]       err_gain, int_gain, att_gain, damp_gain;
  logic [LIMIT_W-1:0]      int_limit;
  longint                  integ_acc;
  logic [OUT_W-1:0]        elevator_expected[$];
  int                      mismatches;

  // divide with rounding to nearest, ties away from zero
  function automatic longint round_div(longint num, longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // one control tick; advances the integrator
  function automatic logic [OUT_W-1:0] predict_elevator(longint err, longint pitch,
                                                          longint rate);
    longint e, p, s, k, mag, t, y;
    e = clip(err + longint'(alt_offset), E_LIMIT);
    p = clip(round_div(e * longint'(err_gain), 65536), P_LIMIT);
    integ_acc = clip(integ_acc + round_div(e * longint'(int_gain), INTEG_SCALE),
                     longint'(int_limit) * 256);
    s = clip(p * 256 + integ_acc, SUM_LIMIT);
    mag = (pitch < 0) ? -pitch : pitch;
    k = longint'(att_gain);
    if (mag >= GAIN_KNEE)
      k = k + round_div(mag * GAIN_SLOPE, 256);
    t = s * 256 - pitch * k - rate * longint'(damp_gain);
    y = clip(round_div(t, OUT_SCALE), OUT_LIMIT);
    return y[OUT_W-1:0];
  endfunction

  always @(posedge clk) begin
    logic [OUT_W-1:0] want;
    if (!rst_n) begin
      alt_offset = RST_ALT_OFFSET;
      err_gain   = RST_ERROR_GAIN;
      int_gain   = RST_INTEGRAL_GAIN;
      att_gain   = RST_ATTITUDE_GAIN;
      damp_gain  = RST_DAMPING_GAIN;
      int_limit  = RST_INTEG_LIMIT;
      integ_acc  = 0;
      mismatches = 0;
      elevator_expected.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ALT_OFFSET:    alt_offset = cfg_data[OFF_W-1:0];
          REG_ERROR_GAIN:    err_gain   = cfg_data[GAIN_W-1:0];
          REG_INTEGRAL_GAIN: int_gain   = cfg_data[GAIN_W-1:0];
          REG_ATTITUDE_GAIN: att_gain   = cfg_data[GAIN_W-1:0];
          REG_DAMPING_GAIN:  damp_gain  = cfg_data[GAIN_W-1:0];
          REG_INTEG_LIMIT:   int_limit  = cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        elevator_expected.push_back(predict_elevator(
          longint'($signed(in_tdata[ERR_W-1:0])),
          longint'($signed(in_tdata[ERR_W +: PITCH_W])),
          longint'($signed(in_tdata[ERR_W+PITCH_W +: RATE_W]))));
      if (out_tvalid && out_tready) begin
        if (elevator_expected.size() == 0) begin
          $error("elevator_command: no item expected, actual %0d",
                 $signed(out_tdata[OUT_W-1:0]));
          mismatches++;
        end else begin
          want = elevator_expected.pop_front();
          if (out_tdata[OUT_W-1:0] !== want) begin
            $error("elevator_command: expected %0d, actual %0d",
                   $signed(want), $signed(out_tdata[OUT_W-1:0]));
            mismatches++;
          end
          if (out_tdata[OUT_DATA_W-1:OUT_W] !== '0) begin
            $error("out_tdata padding: expected 0, actual %0h",
                   out_tdata[OUT_DATA_W-1:OUT_W]);
            mismatches++;
          end
        end
      end
    end
    mismatch_count <= mismatches;
    awaiting_count <= elevator_expected.size();
  end

endmodule

### dv/tb_altitude_hold_pitch_loop.sv
`timescale 1ns / 1ps

module tb_altitude_hold_pitch_loop
  import ahpl_pkg::*;
;

  // run shape: random items per setting, settings per idling mode
  localparam int ITEMS_PER_SET = 84;
  localparam int SETS_PER_MODE = 4;
  // long receiver hold-off, well past one item time so the input stalls
  localparam int HOLD_SPAN     = 3000;
  // watchdog limit on the whole run
  localparam int CYCLE_LIMIT   = 1500000;
  // drain time after the last settle, ahead of the verdict
  localparam int DRAIN_CYCLES  = 130;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;    // altitude_error, pitch_angle, pitch_rate
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;        // elevator_command
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_ALT_OFFSET;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int   mismatch_count;
  int   awaiting_count;

  // idling controls, percent of cycles
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_armed = 1'b0;
  int   hold_spent = 0;
  int   cycle_count = 0;
  int   err_bias = 0;

  always #10 clk = ~clk;

  altitude_hold_pitch_loop dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  pitch_loop_checker loop_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .awaiting_count (awaiting_count)
  );

  // receiver: one long hold-off when armed, otherwise random stalls
  always @(posedge clk) begin
    if (hold_armed && hold_spent < HOLD_SPAN) begin
      hold_spent <= hold_spent + 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // random value in -n..n
  function automatic int spread(int n);
    return int'($urandom_range(0, 2 * n)) - n;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gain(int typical);
    case ($urandom_range(9))
      0:       return CFG_DATA_W'($urandom);     // upper bits set too, masked by the block
      1, 2, 3: return CFG_DATA_W'($urandom_range(0, 262143));
      default: return CFG_DATA_W'($urandom_range(0, typical));
    endcase
  endfunction

  // idle cycles go in front, so valid never drops and rises in one step;
  // valid stays up after the handshake for the next item
  task automatic send_item(input logic [ERR_W-1:0] err, input logic [PITCH_W-1:0] pitch,
                           input logic [RATE_W-1:0] rate);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= {{(IN_DATA_W-ERR_W-PITCH_W-RATE_W){1'b0}}, rate, pitch, err};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  // register write; cfg_valid is lowered by the caller after the last one
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] offset, err_g, int_g, att_g,
                              input logic [CFG_DATA_W-1:0] damp_g, limit, input bit stray);
    write_reg(REG_ALT_OFFSET, offset);
    write_reg(REG_ERROR_GAIN, err_g);
    write_reg(REG_INTEGRAL_GAIN, int_g);
    write_reg(REG_ATTITUDE_GAIN, att_g);
    write_reg(REG_DAMPING_GAIN, damp_g);
    write_reg(REG_INTEG_LIMIT, limit);
    // indexes past the register list must be ignored
    if (stray)
      write_reg(CFG_IDX_W'(REG_INTEG_LIMIT + 1 + $urandom_range(1)), CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // stop offering and wait until every result has come back
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (awaiting_count != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic random_setting();
    logic [CFG_DATA_W-1:0] offset, limit;
    case ($urandom_range(9))
      0:       offset = CFG_DATA_W'($urandom);   // can exceed the nominal range
      1, 2:    offset = CFG_DATA_W'(spread(1152000));
      default: offset = CFG_DATA_W'(spread(6000));
    endcase
    case ($urandom_range(9))
      0:       limit = CFG_DATA_W'($urandom);    // up to 16383 after masking
      1:       limit = '0;
      default: limit = CFG_DATA_W'($urandom_range(0, 11520));
    endcase
    program_regs(offset, pick_gain(120000), pick_gain(30000), pick_gain(80000),
                 pick_gain(8000), limit, $urandom_range(3) == 0);
    // a steady error bias lets the integrator wind up to its clamp
    err_bias = ($urandom_range(2) == 0) ? 0 : spread(6000);
  endtask

  task automatic random_items(input int count);
    int err, pitch, rate;
    for (int i = 0; i < count; i++) begin
      err   = ($urandom_range(5) == 0) ? int'($urandom) : err_bias + spread(3000);
      pitch = ($urandom_range(5) == 0) ? int'($urandom) : spread(5000);
      rate  = ($urandom_range(5) == 0) ? int'($urandom) : spread(20000);
      send_item(ERR_W'(err), PITCH_W'(pitch), RATE_W'(rate));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: field extremes, both sides of the gain schedule knee
    send_item(0, 0, 0);
    send_item(24'h7FFFFF, 16'h7FFF, 20'h7FFFF);
    send_item(24'h800000, 16'h8000, 20'h80000);
    send_item(5120, 2560, 0);
    send_item(ERR_W'(-5120), PITCH_W'(-2560), 0);
    send_item(5121, 2559, 1);
    send_item(ERR_W'(-5121), PITCH_W'(-2559), RATE_W'(-1));
    send_item(256, 0, 256);
    send_item(ERR_W'(-256), 1, RATE_W'(-256));
    settle();

    // all gains at max, offset at its top, limit above its nominal range
    program_regs(1152000, 262143, 262143, 262143, 262143, 16383, 1'b1);
    send_item(24'h7FFFFF, 16'h7FFF, 0);
    send_item(0, 0, 0);
    send_item(2000, 100, 0);
    send_item(24'h800000, 16'h8000, 20'h7FFFF);
    settle();

    // integrator wound up; zero integral gain must still clamp to the new limit
    program_regs(0, CFG_DATA_W'(RST_ERROR_GAIN), 0, CFG_DATA_W'(RST_ATTITUDE_GAIN),
                 CFG_DATA_W'(RST_DAMPING_GAIN), 100, 1'b0);
    send_item(0, 0, 0);
    send_item(1000, PITCH_W'(-3000), 500);
    settle();

    // everything at the bottom, offset at its most negative
    program_regs(CFG_DATA_W'(-1152000), 0, 0, 0, 0, 0, 1'b1);
    send_item(0, 0, 0);
    send_item(24'h7FFFFF, 16'h7FFF, 20'h80000);
    send_item(100, PITCH_W'(-5000), 300);
    settle();

    // random part over three idling modes
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct <= 12;
          recv_idle_pct <= 75;
        end
        1: begin
          send_idle_pct <= 75;
          recv_idle_pct <= 12;
        end
        default: begin
          send_idle_pct <= 0;
          recv_idle_pct <= 0;
        end
      endcase
      for (int set = 0; set < SETS_PER_MODE; set++) begin
        if (mode == 0 && set == 0)
          program_regs(CFG_DATA_W'(RST_ALT_OFFSET), CFG_DATA_W'(RST_ERROR_GAIN),
                       CFG_DATA_W'(RST_INTEGRAL_GAIN), CFG_DATA_W'(RST_ATTITUDE_GAIN),
                       CFG_DATA_W'(RST_DAMPING_GAIN), CFG_DATA_W'(RST_INTEG_LIMIT), 1'b0);
        else
          random_setting();
        // receiver goes quiet while items keep coming back to back
        if (mode == 2 && set == 0)
          hold_armed <= 1'b1;
        random_items(ITEMS_PER_SET);
        settle();
      end
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && awaiting_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
